// ----- design/fmm_pkg.sv -----
// Shared types and constants for the mass-matrix MSR stencil block.
// No dependencies; used by every module of the block.
`default_nettype none
package fmm_pkg;

  localparam int CELL_W  = 10;
  localparam int WID_W   = CELL_W + 1;
  localparam int IDX_W   = 23;
  localparam int UNIT_W  = 32;
  localparam int COEFF_W = 36;
  localparam int WT_W    = 4;
  localparam int NB_N    = 6;
  localparam int SLOT_N  = NB_N + 2;
  localparam int SLOT_W  = 3;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    KIND_DIAG  = 2'd0,
    KIND_OFF   = 2'd1,
    KIND_CLOSE = 2'd2
  } entry_kind_e;

  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS_UNIT = 2'd2;

  // one classified node, handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0] node_idx;
    logic [WID_W-1:0] width;
    logic [IDX_W-1:0] n_nodes;
    logic [IDX_W-1:0] rp;
    logic [IDX_W-1:0] rp_end;
    logic             xlo;
    logic             xhi;
    logic             ylo;
    logic             yhi;
    logic             last_node;
  } node_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

// ----- design/fmm_front.sv -----
// Front end: accepts grid nodes, clamps them, classifies neighbors and tracks
// the running row pointer. Depends on fmm_pkg.
`default_nettype none
module fmm_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [fmm_pkg::CELL_W-1:0]   cells_x_i,
  input  wire logic [fmm_pkg::CELL_W-1:0]   cells_y_i,
  input  wire logic                         in_valid_i,
  input  wire logic [fmm_pkg::CELL_W-1:0]   node_col_i,
  input  wire logic [fmm_pkg::CELL_W-1:0]   node_row_i,
  input  wire logic                         restart_i,
  input  wire fmm_pkg::queue_status_t       q_status_i,
  output logic                              push_o,
  output fmm_pkg::node_desc_t               desc_o
);

  logic [fmm_pkg::CELL_W-1:0] nx, ny, col, row;
  logic [fmm_pkg::WID_W-1:0]  w, ny1;
  logic [2*fmm_pkg::WID_W-1:0] nodes_full;
  logic [fmm_pkg::CELL_W+fmm_pkg::WID_W-1:0] row_off;
  logic [fmm_pkg::IDX_W-1:0]  n_nodes, rp_base, rp_q, rp_d;
  logic xlo, xhi, ylo, yhi;
  logic [fmm_pkg::NB_N-1:0] present;
  logic [2:0] m;

  always_comb begin
    nx  = (cells_x_i == '0) ? fmm_pkg::CELL_W'(1) : cells_x_i;
    ny  = (cells_y_i == '0) ? fmm_pkg::CELL_W'(1) : cells_y_i;
    col = (node_col_i > nx) ? nx : node_col_i;
    row = (node_row_i > ny) ? ny : node_row_i;
    w   = {1'b0, nx} + fmm_pkg::WID_W'(1);
    ny1 = {1'b0, ny} + fmm_pkg::WID_W'(1);
    nodes_full = w * ny1;
    row_off    = row * w;
    n_nodes    = fmm_pkg::IDX_W'(nodes_full);
    xlo = (col != '0);
    xhi = (col < nx);
    ylo = (row != '0);
    yhi = (row < ny);
    present = {xhi & yhi, yhi, xlo, xlo & ylo, ylo, xhi};
    m = 3'($countones(present));
    rp_base = restart_i ? (n_nodes + fmm_pkg::IDX_W'(1)) : rp_q;
    rp_d    = rp_base + fmm_pkg::IDX_W'(m);

    desc_o.node_idx  = fmm_pkg::IDX_W'(row_off) + fmm_pkg::IDX_W'(col);
    desc_o.width     = w;
    desc_o.n_nodes   = n_nodes;
    desc_o.rp        = rp_base;
    desc_o.rp_end    = rp_d;
    desc_o.xlo       = xlo;
    desc_o.xhi       = xhi;
    desc_o.ylo       = ylo;
    desc_o.yhi       = yhi;
    desc_o.last_node = (col == nx) && (row == ny);
  end

  assign push_o = in_valid_i && !q_status_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= '0;
    end else if (push_o) begin
      rp_q <= rp_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/fmm_queue.sv -----
// Short FIFO of node descriptors between front and back.
// Depends on fmm_pkg.
`default_nettype none
module fmm_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire fmm_pkg::node_desc_t   wdata_i,
  input  wire logic                  pop_i,
  output fmm_pkg::node_desc_t        rdata_o,
  output fmm_pkg::queue_status_t     status_o
);

  fmm_pkg::node_desc_t mem_q [fmm_pkg::QDEPTH];
  logic [fmm_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [fmm_pkg::QPTR_W:0]   cnt_q;

  assign status_o.full  = (cnt_q == (fmm_pkg::QPTR_W+1)'(fmm_pkg::QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + fmm_pkg::QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + fmm_pkg::QPTR_W'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (fmm_pkg::QPTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (fmm_pkg::QPTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/fmm_back.sv -----
// Back end: walks head-descriptor entries into the output register, one per
// cycle unless stalled, scaling weights by the mass unit. Depends on fmm_pkg.
`default_nettype none
module fmm_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [fmm_pkg::UNIT_W-1:0]    mass_unit_i,
  input  wire fmm_pkg::node_desc_t           desc_i,
  input  wire fmm_pkg::queue_status_t        q_status_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         entry_kind_o,
  output logic [fmm_pkg::IDX_W-1:0]          position_o,
  output logic [fmm_pkg::IDX_W-1:0]          index_word_o,
  output logic [fmm_pkg::COEFF_W-1:0]        coeff_o,
  output logic                               last_o
);

  logic [fmm_pkg::SLOT_N-1:0] done_q, full_mask, pending, sel;
  logic [2:0] k_q;
  logic [fmm_pkg::SLOT_W-1:0] slot;
  logic [fmm_pkg::NB_N-1:0] present;
  logic [fmm_pkg::WT_W-1:0] wx, wy, wt, diag_wt;
  logic [fmm_pkg::IDX_W-1:0] wext, base;
  logic advance, last_entry, is_nb;
  fmm_pkg::entry_kind_e kind;
  logic [fmm_pkg::IDX_W-1:0] pos, idx;
  logic [fmm_pkg::COEFF_W-1:0] prod;

  logic                          valid_q;
  logic [1:0]                    kind_q;
  logic [fmm_pkg::IDX_W-1:0]     pos_q, idx_q;
  logic [fmm_pkg::COEFF_W-1:0]   coeff_q;
  logic                          last_q;

  always_comb begin
    wx = fmm_pkg::WT_W'(desc_i.xlo) + fmm_pkg::WT_W'(desc_i.xhi);
    wy = fmm_pkg::WT_W'(desc_i.ylo) + fmm_pkg::WT_W'(desc_i.yhi);
    present = {desc_i.xhi & desc_i.yhi, desc_i.yhi, desc_i.xlo,
               desc_i.xlo & desc_i.ylo, desc_i.ylo, desc_i.xhi};
    // diagonal = sum of the present neighbor weights
    diag_wt = (present[0] ? wy : '0) + (present[1] ? wx : '0)
            + (present[2] ? fmm_pkg::WT_W'(2) : '0) + (present[3] ? wy : '0)
            + (present[4] ? wx : '0) + (present[5] ? fmm_pkg::WT_W'(2) : '0);
    full_mask = {desc_i.last_node, present, 1'b1};
    pending   = full_mask & ~done_q;
    sel       = pending & (~pending + fmm_pkg::SLOT_N'(1));
    slot = '0;
    for (int s = fmm_pkg::SLOT_N - 1; s >= 0; s--) begin
      if (pending[s]) slot = fmm_pkg::SLOT_W'(s);
    end
    last_entry = ((pending & ~sel) == '0);
    is_nb = (slot != '0) && (slot != fmm_pkg::SLOT_W'(fmm_pkg::SLOT_N - 1));

    wext = fmm_pkg::IDX_W'(desc_i.width);
    base = desc_i.node_idx;
    kind = fmm_pkg::KIND_OFF;
    pos  = desc_i.rp + fmm_pkg::IDX_W'(k_q);
    idx  = base;
    wt   = '0;
    unique case (slot)
      3'd0: begin
        kind = fmm_pkg::KIND_DIAG;
        pos  = base;
        idx  = desc_i.rp;
        wt   = diag_wt;
      end
      3'd1: begin idx = base + fmm_pkg::IDX_W'(1);        wt = wy; end
      3'd2: begin idx = base - wext;                      wt = wx; end
      3'd3: begin idx = base - wext - fmm_pkg::IDX_W'(1); wt = fmm_pkg::WT_W'(2); end
      3'd4: begin idx = base - fmm_pkg::IDX_W'(1);        wt = wy; end
      3'd5: begin idx = base + wext;                      wt = wx; end
      3'd6: begin idx = base + wext + fmm_pkg::IDX_W'(1); wt = fmm_pkg::WT_W'(2); end
      default: begin
        kind = fmm_pkg::KIND_CLOSE;
        pos  = desc_i.n_nodes;
        idx  = desc_i.rp_end;
        wt   = '0;
      end
    endcase
    prod = fmm_pkg::COEFF_W'(wt) * fmm_pkg::COEFF_W'(mass_unit_i);
  end

  assign advance = !q_status_i.empty && (!valid_q || !out_stall_i);
  assign pop_o   = advance && last_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= '0;
      k_q     <= '0;
    end else begin
      if (!valid_q || !out_stall_i) valid_q <= !q_status_i.empty;
      if (advance) begin
        if (last_entry) begin
          done_q <= '0;
          k_q    <= '0;
        end else begin
          done_q <= done_q | sel;
          if (is_nb) k_q <= k_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q  <= kind;
      pos_q   <= pos;
      idx_q   <= idx;
      coeff_q <= prod;
      last_q  <= last_entry;
    end
  end

  assign out_valid_o  = valid_q;
  assign entry_kind_o = kind_q;
  assign position_o   = pos_q;
  assign index_word_o = idx_q;
  assign coeff_o      = coeff_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire

// ----- design/fem_mass_matrix_msr_stencil.sv -----
// Top level of the P1 mass-matrix MSR stencil: config registers, front end,
// descriptor queue and back end. Depends on fmm_pkg and the fmm_* modules.
//
// Usage:
//   Config: write cells_x (index 0), cells_y (1), mass_unit (2) through the
//   cfg port while no nodes are in flight; cfg_ready_o is always high.
//   Input: one grid node per accepted transfer (in_valid_i high, in_stall_o
//   low). The front end classifies a node combinationally and queues it, so a
//   node can be accepted every cycle until the four-entry queue fills.
//   Output: each node yields 3 to 7 entries (diagonal, 2..6 off-diagonal,
//   closing pointer at the last node), one per cycle unless out_stall_i holds
//   the back end's output register; last_o flags the final entry of a node.
//   Path: an accepted node is written into the queue; its entries then pass,
//   one after another, through the single output register of the back end,
//   so the queue can take new nodes while the back end is busy with one.
//   Stall: out_stall_i holds the output register; the queue absorbs up to
//   four nodes before in_stall_o rises.
//   Reset: row pointer 0, queue empty, cells_x = cells_y = 1, mass_unit = 0.
`default_nettype none
module fem_mass_matrix_msr_stencil (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [fmm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [fmm_pkg::UNIT_W-1:0]        cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [fmm_pkg::CELL_W-1:0]        node_col_i,
  input  wire logic [fmm_pkg::CELL_W-1:0]        node_row_i,
  input  wire logic                              restart_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [1:0]                             entry_kind_o,
  output logic [fmm_pkg::IDX_W-1:0]              position_o,
  output logic [fmm_pkg::IDX_W-1:0]              index_word_o,
  output logic [fmm_pkg::COEFF_W-1:0]            coeff_o,
  output logic                                   last_o
);

  logic [fmm_pkg::CELL_W-1:0] cells_x_q, cells_y_q;
  logic [fmm_pkg::UNIT_W-1:0] mass_unit_q;
  fmm_pkg::node_desc_t    push_desc, head_desc;
  fmm_pkg::queue_status_t q_status;
  logic push, pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_status.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q   <= fmm_pkg::CELL_W'(1);
      cells_y_q   <= fmm_pkg::CELL_W'(1);
      mass_unit_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fmm_pkg::CFG_CELLS_X:   cells_x_q   <= cfg_data_i[fmm_pkg::CELL_W-1:0];
        fmm_pkg::CFG_CELLS_Y:   cells_y_q   <= cfg_data_i[fmm_pkg::CELL_W-1:0];
        fmm_pkg::CFG_MASS_UNIT: mass_unit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fmm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cells_x_i  (cells_x_q),
    .cells_y_i  (cells_y_q),
    .in_valid_i (in_valid_i),
    .node_col_i (node_col_i),
    .node_row_i (node_row_i),
    .restart_i  (restart_i),
    .q_status_i (q_status),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  fmm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_desc),
    .pop_i    (pop),
    .rdata_o  (head_desc),
    .status_o (q_status)
  );

  fmm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mass_unit_i  (mass_unit_q),
    .desc_i       (head_desc),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .entry_kind_o (entry_kind_o),
    .position_o   (position_o),
    .index_word_o (index_word_o),
    .coeff_o      (coeff_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

// ----- tb/fmm_msr_checker.sv -----
// Checker for the mass-matrix MSR stencil: watches the config, node and entry channels,
// predicts every MSR entry of each accepted node and compares it with what the block emits.
// Depends on fmm_pkg for widths and the entry kind codes.
module fmm_msr_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_ready_i,
  input  wire logic [fmm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [fmm_pkg::UNIT_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire logic [fmm_pkg::CELL_W-1:0]    node_col_i,
  input  wire logic [fmm_pkg::CELL_W-1:0]    node_row_i,
  input  wire logic                          restart_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic [1:0]                    entry_kind_i,
  input  wire logic [fmm_pkg::IDX_W-1:0]     position_i,
  input  wire logic [fmm_pkg::IDX_W-1:0]     index_word_i,
  input  wire logic [fmm_pkg::COEFF_W-1:0]   coeff_i,
  input  wire logic                          last_i,
  output int                                 pending_o,
  output int                                 fail_count_o,
  output int                                 entries_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    fmm_pkg::entry_kind_e          kind;
    logic [fmm_pkg::IDX_W-1:0]     pos;
    logic [fmm_pkg::IDX_W-1:0]     idx;
    logic [fmm_pkg::COEFF_W-1:0]   coeff;
    logic                          last;
  } msr_entry_t;

  msr_entry_t                   msr_q[$];
  msr_entry_t                   got;
  msr_entry_t                   want;
  logic [fmm_pkg::CELL_W-1:0]   cells_x_q;
  logic [fmm_pkg::CELL_W-1:0]   cells_y_q;
  logic [fmm_pkg::UNIT_W-1:0]   unit_q;
  logic [fmm_pkg::IDX_W-1:0]    row_ptr_q;

  // Appends the MSR entries of one node and advances the row pointer.
  task automatic expand_node(input logic [fmm_pkg::CELL_W-1:0] col,
                             input logic [fmm_pkg::CELL_W-1:0] row,
                             input logic rs);
    int unsigned nx, ny, i, j, w, nn, m, sum, k;
    int unsigned nb_idx [fmm_pkg::NB_N];
    int unsigned nb_wt [fmm_pkg::NB_N];
    bit          xlo, xhi, ylo, yhi, corner;
    // a zero count acts as one; a 10-bit count never exceeds the cell limit
    nx = (cells_x_q == '0) ? 1 : cells_x_q;
    ny = (cells_y_q == '0) ? 1 : cells_y_q;
    i  = (col > nx) ? nx : col;
    j  = (row > ny) ? ny : row;
    w  = nx + 1;
    nn = w * (ny + 1);
    if (rs) row_ptr_q = fmm_pkg::IDX_W'(nn + 1);
    xlo = (i > 0);
    xhi = (i < nx);
    ylo = (j > 0);
    yhi = (j < ny);
    m = 0;
    if (xhi) begin
      nb_idx[m] = (i + 1) + j * w; nb_wt[m] = int'(ylo) + int'(yhi); m++;
    end
    if (ylo) begin
      nb_idx[m] = i + (j - 1) * w; nb_wt[m] = int'(xlo) + int'(xhi); m++;
    end
    if (xlo && ylo) begin
      nb_idx[m] = (i - 1) + (j - 1) * w; nb_wt[m] = 2; m++;
    end
    if (xlo) begin
      nb_idx[m] = (i - 1) + j * w; nb_wt[m] = int'(ylo) + int'(yhi); m++;
    end
    if (yhi) begin
      nb_idx[m] = i + (j + 1) * w; nb_wt[m] = int'(xlo) + int'(xhi); m++;
    end
    if (xhi && yhi) begin
      nb_idx[m] = (i + 1) + (j + 1) * w; nb_wt[m] = 2; m++;
    end
    sum = 0;
    for (k = 0; k < m; k++) sum += nb_wt[k];
    corner = (i == nx) && (j == ny);
    msr_q.push_back(msr_entry_t'{fmm_pkg::KIND_DIAG, fmm_pkg::IDX_W'(i + j * w), row_ptr_q,
                                 fmm_pkg::COEFF_W'(sum) * fmm_pkg::COEFF_W'(unit_q),
                                 (m == 0) && !corner});
    for (k = 0; k < m; k++) begin
      msr_q.push_back(msr_entry_t'{fmm_pkg::KIND_OFF, fmm_pkg::IDX_W'(row_ptr_q + k),
                                   fmm_pkg::IDX_W'(nb_idx[k]),
                                   fmm_pkg::COEFF_W'(nb_wt[k]) * fmm_pkg::COEFF_W'(unit_q),
                                   (k + 1 == m) && !corner});
    end
    row_ptr_q = fmm_pkg::IDX_W'(row_ptr_q + m);
    // closing pointer only after the far corner node
    if (corner) begin
      msr_q.push_back(msr_entry_t'{fmm_pkg::KIND_CLOSE, fmm_pkg::IDX_W'(nn), row_ptr_q,
                                   '0, 1'b1});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q      = fmm_pkg::CELL_W'(1);
      cells_y_q      = fmm_pkg::CELL_W'(1);
      unit_q         = '0;
      row_ptr_q      = '0;
      msr_q.delete();
      pending_o      = 0;
      fail_count_o   = 0;
      entries_seen_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          fmm_pkg::CFG_CELLS_X:   cells_x_q = cfg_data_i[fmm_pkg::CELL_W-1:0];
          fmm_pkg::CFG_CELLS_Y:   cells_y_q = cfg_data_i[fmm_pkg::CELL_W-1:0];
          fmm_pkg::CFG_MASS_UNIT: unit_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expand_node(node_col_i, node_row_i, restart_i);
      if (out_valid_i && !out_stall_i) begin
        got = {entry_kind_i, position_i, index_word_i, coeff_i, last_i};
        entries_seen_o++;
        if (msr_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t unexpected entry: kind %0d pos %0d idx %0d coeff 0x%09h last %0b",
                     $realtime, got.kind, got.pos, got.idx, got.coeff, got.last);
        end else begin
          want = msr_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= MAX_REPORTS) begin
              $display("%0t mismatch: exp kind %0d pos %0d idx %0d coeff 0x%09h last %0b",
                       $realtime, want.kind, want.pos, want.idx, want.coeff, want.last);
              $display("    got kind %0d pos %0d idx %0d coeff 0x%09h last %0b",
                       got.kind, got.pos, got.idx, got.coeff, got.last);
            end
          end
        end
      end
      pending_o = msr_q.size();
    end
  end

endmodule

// ----- tb/tb_fem_mass_matrix_msr_stencil.sv -----
// Top of the mass-matrix MSR stencil testbench: clock, reset, node and config stimulus,
// random output stalls, watchdog and verdict. Uses fmm_pkg and the fmm_msr_checker module.
module tb_fem_mass_matrix_msr_stencil;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 2000;
  localparam int NODE_TARGET = 270;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          cfg_valid   = 1'b0;
  logic [fmm_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
  logic [fmm_pkg::UNIT_W-1:0]    cfg_data    = '0;
  logic                          in_valid    = 1'b0;
  logic [fmm_pkg::CELL_W-1:0]    node_col    = '0;
  logic [fmm_pkg::CELL_W-1:0]    node_row    = '0;
  logic                          restart     = 1'b0;
  logic                          out_stall   = 1'b0;
  logic                          cfg_ready_o;
  logic                          in_stall_o;
  logic                          out_valid_o;
  logic [1:0]                    entry_kind_o;
  logic [fmm_pkg::IDX_W-1:0]     position_o;
  logic [fmm_pkg::IDX_W-1:0]     index_word_o;
  logic [fmm_pkg::COEFF_W-1:0]   coeff_o;
  logic                          last_o;

  int          pending;
  int          fail_count;
  int          entries_seen;
  int          nodes_sent   = 0;
  int          settings_cnt = 0;
  int          idle_cycles  = 0;
  int unsigned stall_left   = 0;
  int unsigned rx_wait;
  bit          tx_quiet     = 1'b1;
  bit          rx_quiet     = 1'b0;

  fem_mass_matrix_msr_stencil u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .node_col_i   (node_col),
    .node_row_i   (node_row),
    .restart_i    (restart),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .entry_kind_o (entry_kind_o),
    .position_o   (position_o),
    .index_word_o (index_word_o),
    .coeff_o      (coeff_o),
    .last_o       (last_o)
  );

  fmm_msr_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall_o),
    .node_col_i     (node_col),
    .node_row_i     (node_row),
    .restart_i      (restart),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall),
    .entry_kind_i   (entry_kind_o),
    .position_i     (position_o),
    .index_word_i   (index_word_o),
    .coeff_i        (coeff_o),
    .last_i         (last_o),
    .pending_o      (pending),
    .fail_count_o   (fail_count),
    .entries_seen_o (entries_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: after each accepted entry, may hold stall, counted down in stall_left
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid_o && !out_stall) begin
      rx_wait = rx_quiet ? 0 : $urandom_range(0, 6);
      stall_left <= rx_wait;
      out_stall  <= (rx_wait != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready_o) || (in_valid && !in_stall_o) ||
        (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d entries pending", IDLE_LIMIT, pending);
      $display("tb_fem_mass_matrix_msr_stencil NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic write_reg(input logic [fmm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fmm_pkg::UNIT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic [fmm_pkg::CELL_W-1:0] cx,
                           input logic [fmm_pkg::CELL_W-1:0] cy,
                           input logic [fmm_pkg::UNIT_W-1:0] unit);
    // upper data bits are don't-care for the cell count registers
    write_reg(fmm_pkg::CFG_CELLS_X, {22'($urandom()), cx});
    write_reg(fmm_pkg::CFG_CELLS_Y, {22'($urandom()), cy});
    write_reg(fmm_pkg::CFG_MASS_UNIT, unit);
    cfg_valid <= 1'b0;
    settings_cnt++;
  endtask

  task automatic send_node(input logic [fmm_pkg::CELL_W-1:0] col,
                           input logic [fmm_pkg::CELL_W-1:0] row,
                           input logic rs);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    node_col <= col;
    node_row <= row;
    restart  <= rs;
    do @(posedge clk); while (in_stall_o);
    nodes_sent++;
  endtask

  // wait until every predicted entry has come out, then a short pause
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned cx, cy, nx, ny, sel, cut, cnt, r, c;
    logic [fmm_pkg::UNIT_W-1:0] unit;
    bit rs_first;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 1x1 grid, zero unit, row pointer from zero
    send_node(0, 0, 1'b0);
    send_node(1, 0, 1'b0);
    send_node(0, 1, 1'b0);
    send_node(1, 1, 1'b0);
    send_node(10'h3FF, 10'h3FF, 1'b1);
    settle();

    // zero cell counts act as one, largest unit
    configure(0, 0, 32'hFFFF_FFFF);
    send_node(1, 1, 1'b1);
    send_node(0, 0, 1'b0);
    send_node(512, 3, 1'b0);
    settle();

    // unused register index must be ignored
    write_reg(2'd3, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    rx_quiet = 1'b1;
    send_node(0, 1, 1'b0);
    settle();

    // largest grid: corners, edges, interior
    configure(10'd1023, 10'd1023, $urandom());
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    send_node(0, 0, 1'b1);
    send_node(1023, 0, 1'b0);
    send_node(0, 1023, 1'b0);
    send_node(1023, 1023, 1'b0);
    send_node(512, 700, 1'b0);
    send_node(1023, 511, 1'b0);
    send_node(0, 511, 1'b1);
    send_node(511, 0, 1'b0);
    settle();

    while (nodes_sent < NODE_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        cx = $urandom_range(1, 6);
        cy = $urandom_range(1, 6);
      end else if (sel < 9) begin
        cx = $urandom_range(1, 1023);
        cy = $urandom_range(0, 3);
      end else begin
        cx = $urandom_range(0, 1023);
        cy = $urandom_range(0, 1023);
      end
      sel = $urandom_range(0, 7);
      unit = (sel == 0) ? '0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom();
      configure(fmm_pkg::CELL_W'(cx), fmm_pkg::CELL_W'(cy), unit);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      nx = (cx == 0) ? 1 : cx;
      ny = (cy == 0) ? 1 : cy;
      rs_first = ($urandom_range(0, 5) != 0);
      if ((nx + 1) * (ny + 1) <= 49) begin
        // row-major sweep of the grid, sometimes cut short
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, (nx + 1) * (ny + 1))
                                          : (nx + 1) * (ny + 1);
        cnt = 0;
        for (r = 0; r <= ny; r++) begin
          for (c = 0; c <= nx; c++) begin
            if (cnt < cut) begin
              send_node(fmm_pkg::CELL_W'(c), fmm_pkg::CELL_W'(r), (cnt == 0) && rs_first);
            end
            cnt++;
          end
        end
      end else begin
        send_node(fmm_pkg::CELL_W'($urandom_range(0, nx)),
                  fmm_pkg::CELL_W'($urandom_range(0, ny)), rs_first);
        repeat (11) begin
          send_node(fmm_pkg::CELL_W'($urandom_range(0, nx)),
                    fmm_pkg::CELL_W'($urandom_range(0, ny)),
                    $urandom_range(0, 15) == 0);
        end
      end
      // noise: any coordinates, random restart
      repeat ($urandom_range(0, 3)) begin
        send_node(fmm_pkg::CELL_W'($urandom_range(0, 1023)),
                  fmm_pkg::CELL_W'($urandom_range(0, 1023)),
                  $urandom_range(0, 1));
      end
      settle();
    end

    repeat (20) @(posedge clk);
    $display("ran %0d nodes over %0d grid settings; %0d MSR entries checked, %0d failures",
             nodes_sent, settings_cnt, entries_seen, fail_count);
    if (pending != 0) $display("%0d expected entries never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_fem_mass_matrix_msr_stencil OK");
    end else begin
      $display("tb_fem_mass_matrix_msr_stencil NOT OK");
    end
    $finish;
  end

endmodule
